[hw/rtl/mqtt_control_packet_framer_macros.svh]
// ----------------------------------------------------------------------------
// MQTT control packet framer assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MQTT_CONTROL_PACKET_FRAMER_MACROS_SVH
`define MQTT_CONTROL_PACKET_FRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCPF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MCPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

[hw/rtl/mcpf_pkg.sv]
// ----------------------------------------------------------------------------
// MQTT control packet framer package
// Shared types, codes and constants of the framer.
// ----------------------------------------------------------------------------
package mcpf_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] CMD_CONNECT   = 3'd0;
    localparam logic [2:0] CMD_PUBLISH   = 3'd1;
    localparam logic [2:0] CMD_SUBSCRIBE = 3'd2;
    localparam logic [2:0] CMD_PING      = 3'd3;
    localparam logic [2:0] CMD_BODY      = 3'd4;

    localparam logic [1:0] CFG_KEEPALIVE = 2'd0;
    localparam logic [1:0] CFG_CID_LEN   = 2'd1;
    localparam logic [1:0] CFG_FLAGS     = 2'd2;

    localparam logic [15:0] KEEPALIVE_RESET = 16'd60;
    localparam logic [15:0] CID_LEN_RESET   = 16'd12;
    localparam logic [7:0]  FLAGS_RESET     = 8'h02;

    localparam logic [7:0] HDR_CONNECT   = 8'h10;
    localparam logic [7:0] HDR_PUBLISH   = 8'h30;
    localparam logic [7:0] HDR_SUBSCRIBE = 8'h82;
    localparam logic [7:0] HDR_PING      = 8'hC0;
    localparam logic [7:0] VARINT_MORE   = 8'h80;
    localparam logic [7:0] PROTO_LEVEL   = 8'h04;
    localparam logic [7:0] NAME_LENGTH   = 8'h04;
    localparam logic [7:0] QOS_BYTE      = 8'h00;

    localparam logic [17:0] CONNECT_FIXED_LEN   = 18'd12;
    localparam logic [17:0] PUBLISH_FIXED_LEN   = 18'd2;
    localparam logic [17:0] SUBSCRIBE_FIXED_LEN = 18'd5;

    typedef enum logic [1:0] {
        KIND_CONNECT,
        KIND_PUBLISH,
        KIND_SUBSCRIBE,
        KIND_PING
    } t_kind;

    typedef enum logic [2:0] {
        OP_CONNECT,
        OP_PUBLISH,
        OP_SUBSCRIBE,
        OP_PING,
        OP_BODY
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [17:0] rem_len;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [7:0]  data;
        logic        fin;
        logic        add_qos;
    } t_desc;

endpackage

[hw/rtl/mcpf_front.sv]
// ----------------------------------------------------------------------------
// MQTT framer front end
// Holds the configuration and packet state, classifies input transactions and
// queues one job descriptor per transaction that produces output.
// ----------------------------------------------------------------------------
module mcpf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_full,
    output logic           o_ready,
    input  logic [2:0]     i_command,
    input  logic [15:0]    i_topic_length,
    input  logic [15:0]    i_payload_length,
    input  logic [7:0]     i_body_byte,
    input  logic           i_body_last,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    output logic           o_push,
    output mcpf_pkg::t_desc o_desc
);

    logic [15:0]         r_keepalive;
    logic [15:0]         r_cid_len;
    logic [7:0]          r_flags;
    logic [15:0]         r_pid;
    logic [15:0]         n_pid;
    mcpf_pkg::t_kind     r_kind;
    mcpf_pkg::t_kind     n_kind;
    logic                r_open;
    logic                n_open;
    logic                accept;
    logic                produce;
    logic [16:0]         pub_sum;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && produce;
    assign pub_sum = {1'b0, i_topic_length} + {1'b0, i_payload_length};

    always_comb begin
        produce        = 1'b0;
        n_pid          = r_pid;
        n_kind         = r_kind;
        n_open         = r_open;
        o_desc.op      = mcpf_pkg::OP_BODY;
        o_desc.rem_len = '0;
        o_desc.word_a  = i_topic_length;
        o_desc.word_b  = r_pid;
        o_desc.data    = i_body_byte;
        o_desc.fin     = 1'b0;
        o_desc.add_qos = 1'b0;
        case (i_command)
            mcpf_pkg::CMD_CONNECT: begin
                produce        = 1'b1;
                n_kind         = mcpf_pkg::KIND_CONNECT;
                n_open         = (r_cid_len != 16'd0);
                o_desc.op      = mcpf_pkg::OP_CONNECT;
                o_desc.rem_len = mcpf_pkg::CONNECT_FIXED_LEN + {2'b0, r_cid_len};
                o_desc.word_a  = r_cid_len;
                o_desc.word_b  = r_keepalive;
                o_desc.data    = r_flags;
                o_desc.fin     = (r_cid_len == 16'd0);
            end
            mcpf_pkg::CMD_PUBLISH: begin
                produce        = 1'b1;
                n_kind         = mcpf_pkg::KIND_PUBLISH;
                n_open         = (pub_sum != 17'd0);
                o_desc.op      = mcpf_pkg::OP_PUBLISH;
                o_desc.rem_len = mcpf_pkg::PUBLISH_FIXED_LEN + {1'b0, pub_sum};
                o_desc.fin     = (pub_sum == 17'd0);
            end
            mcpf_pkg::CMD_SUBSCRIBE: begin
                produce        = 1'b1;
                n_kind         = mcpf_pkg::KIND_SUBSCRIBE;
                n_open         = (i_topic_length != 16'd0);
                n_pid          = r_pid + 16'd1;
                o_desc.op      = mcpf_pkg::OP_SUBSCRIBE;
                o_desc.rem_len = mcpf_pkg::SUBSCRIBE_FIXED_LEN + {2'b0, i_topic_length};
                o_desc.fin     = (i_topic_length == 16'd0);
                o_desc.add_qos = (i_topic_length == 16'd0);
            end
            mcpf_pkg::CMD_PING: begin
                produce        = 1'b1;
                n_kind         = mcpf_pkg::KIND_PING;
                n_open         = 1'b0;
                o_desc.op      = mcpf_pkg::OP_PING;
                o_desc.fin     = 1'b1;
            end
            mcpf_pkg::CMD_BODY: begin
                produce        = r_open;
                o_desc.fin     = i_body_last;
                o_desc.add_qos = i_body_last && (r_kind == mcpf_pkg::KIND_SUBSCRIBE);
                if (i_body_last) begin
                    n_open = 1'b0;
                end
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid  <= 16'd1;
            r_kind <= mcpf_pkg::KIND_CONNECT;
            r_open <= 1'b0;
        end else if (accept) begin
            r_pid  <= n_pid;
            r_kind <= n_kind;
            r_open <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keepalive <= mcpf_pkg::KEEPALIVE_RESET;
            r_cid_len   <= mcpf_pkg::CID_LEN_RESET;
            r_flags     <= mcpf_pkg::FLAGS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mcpf_pkg::CFG_KEEPALIVE: r_keepalive <= i_cfg_data;
                mcpf_pkg::CFG_CID_LEN:   r_cid_len   <= i_cfg_data;
                mcpf_pkg::CFG_FLAGS:     r_flags     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/mcpf_queue.sv]
// ----------------------------------------------------------------------------
// MQTT framer job queue
// Small register FIFO of job descriptors between the front and back ends.
// ----------------------------------------------------------------------------
`include "mqtt_control_packet_framer_macros.svh"

module mcpf_queue #(
    parameter int Depth = mcpf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mcpf_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mcpf_pkg::t_desc o_head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);

    mcpf_pkg::t_desc r_mem [Depth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic [PtrW-1:0] n_wr;
    logic [PtrW-1:0] n_rd;
    logic [CntW-1:0] n_cnt;

    assign o_full  = (r_cnt == FullCnt);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    `MCPF_ASSERT_SAME(a_no_overflow, i_push, !o_full)
    `MCPF_ASSERT_SAME(a_no_underflow, i_pop, !o_empty)
    `MCPF_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1)
    `MCPF_ASSERT_NEXT(a_count_down, i_pop && !i_push, r_cnt == $past(r_cnt) - 1'b1)

endmodule

[hw/rtl/mcpf_back.sv]
// ----------------------------------------------------------------------------
// MQTT framer back end
// Walks the bytes of the job at the queue head, one byte per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`include "mqtt_control_packet_framer_macros.svh"

module mcpf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  mcpf_pkg::t_desc i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_run_last,
    output logic            o_packet_end
);

    logic [3:0] r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_packet_end;
    logic       adv;
    logic       last_step;
    logic [1:0] nl;
    logic [4:0] total;
    logic [3:0] vidx;
    logic [7:0] cur_byte;
    logic [7:0] vb0;
    logic [7:0] vb1;
    logic [7:0] vb2;
    logic [7:0] hdr;
    logic [7:0] var_byte;

    always_comb begin
        if (i_head.rem_len[17:14] != 4'd0) begin
            nl = 2'd3;
        end else if (i_head.rem_len[13:7] != 7'd0) begin
            nl = 2'd2;
        end else begin
            nl = 2'd1;
        end
    end

    assign vb0  = {(nl != 2'd1), i_head.rem_len[6:0]};
    assign vb1  = {(nl == 2'd3), i_head.rem_len[13:7]};
    assign vb2  = {4'd0, i_head.rem_len[17:14]};
    assign vidx = r_step - {2'd0, nl} - 4'd1;

    always_comb begin
        hdr      = i_head.data;
        var_byte = mcpf_pkg::QOS_BYTE;
        total    = 5'd1;
        case (i_head.op)
            mcpf_pkg::OP_CONNECT: begin
                hdr   = mcpf_pkg::HDR_CONNECT;
                total = 5'd13 + {3'd0, nl};
                case (vidx)
                    4'd0:    var_byte = 8'h00;
                    4'd1:    var_byte = mcpf_pkg::NAME_LENGTH;
                    4'd2:    var_byte = 8'h4D;
                    4'd3:    var_byte = 8'h51;
                    4'd4:    var_byte = 8'h54;
                    4'd5:    var_byte = 8'h54;
                    4'd6:    var_byte = mcpf_pkg::PROTO_LEVEL;
                    4'd7:    var_byte = i_head.data;
                    4'd8:    var_byte = i_head.word_b[15:8];
                    4'd9:    var_byte = i_head.word_b[7:0];
                    4'd10:   var_byte = i_head.word_a[15:8];
                    default: var_byte = i_head.word_a[7:0];
                endcase
            end
            mcpf_pkg::OP_PUBLISH: begin
                hdr      = mcpf_pkg::HDR_PUBLISH;
                total    = 5'd3 + {3'd0, nl};
                var_byte = (vidx == 4'd0) ? i_head.word_a[15:8] : i_head.word_a[7:0];
            end
            mcpf_pkg::OP_SUBSCRIBE: begin
                hdr   = mcpf_pkg::HDR_SUBSCRIBE;
                total = 5'd5 + {3'd0, nl} + {4'd0, i_head.add_qos};
                case (vidx)
                    4'd0:    var_byte = i_head.word_b[15:8];
                    4'd1:    var_byte = i_head.word_b[7:0];
                    4'd2:    var_byte = i_head.word_a[15:8];
                    4'd3:    var_byte = i_head.word_a[7:0];
                    default: var_byte = mcpf_pkg::QOS_BYTE;
                endcase
            end
            mcpf_pkg::OP_PING: begin
                hdr   = mcpf_pkg::HDR_PING;
                total = 5'd1 + {3'd0, nl};
            end
            default: begin
                hdr   = i_head.data;
                total = 5'd1 + {4'd0, i_head.add_qos};
            end
        endcase
    end

    always_comb begin
        if (r_step == 4'd0) begin
            cur_byte = hdr;
        end else if (i_head.op == mcpf_pkg::OP_BODY) begin
            cur_byte = mcpf_pkg::QOS_BYTE;
        end else if (r_step == 4'd1) begin
            cur_byte = vb0;
        end else if (r_step == 4'd2 && nl != 2'd1) begin
            cur_byte = vb1;
        end else if (r_step == 4'd3 && nl == 2'd3) begin
            cur_byte = vb2;
        end else begin
            cur_byte = var_byte;
        end
    end

    assign last_step = ({1'b0, r_step} == total - 5'd1);
    assign adv       = !i_empty && (!r_valid || i_ready);
    assign o_pop     = adv && last_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else if (adv) begin
            r_step  <= last_step ? 4'd0 : r_step + 4'd1;
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_byte       <= cur_byte;
            r_run_last   <= last_step;
            r_packet_end <= last_step && i_head.fin;
        end
    end

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_run_last   = r_run_last;
    assign o_packet_end = r_packet_end;

    `MCPF_ASSERT_SAME(a_step_in_job, !i_empty, {1'b0, r_step} < total)
    `MCPF_ASSERT_NEXT(a_pop_marks_run, o_pop, r_valid && r_run_last)
    `MCPF_ASSERT_NEXT(a_step_restarts, o_pop, r_step == 4'd0)

endmodule

[hw/rtl/mqtt_control_packet_framer.sv]
// ----------------------------------------------------------------------------
// MQTT control packet framer
// Turns start and body transactions into the byte stream of MQTT 3.1.1
// CONNECT, PUBLISH, SUBSCRIBE and PINGREQ packets.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                       Content
// s_axis    in         tdata[47:0], tlast          command/lengths/body byte
// m_axis    out        tdata[7:0], tlast, tuser    packet byte, end, run end
// cfg       in         i_cfg_index, i_cfg_data     keepalive, client id length,
//                                                  connect flags
//
// The front end takes one input transaction per cycle while the job queue has
// room. The back end emits one byte per cycle when not stalled: a start
// transaction makes 2 to 16 bytes, set by its header length, and a body
// byte 1 or 2 bytes. Reset needs no clearing pass.
// A stalled output holds the back end; the queue then fills and stalls input.
// ----------------------------------------------------------------------------
module mqtt_control_packet_framer #(
    parameter int QueueDepth = mcpf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // [2:0] command, [18:3] topic_length, [34:19] payload_length,
    // [42:35] body_byte, [47:43] zero
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // [0] run_last
    output logic        m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    mcpf_pkg::t_desc desc;
    mcpf_pkg::t_desc head;

    assign o_cfg_ready = 1'b1;

    mcpf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .i_full           (full),
        .o_ready          (s_axis_tready),
        .i_command        (s_axis_tdata[2:0]),
        .i_topic_length   (s_axis_tdata[18:3]),
        .i_payload_length (s_axis_tdata[34:19]),
        .i_body_byte      (s_axis_tdata[42:35]),
        .i_body_last      (s_axis_tlast),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_push           (push),
        .o_desc           (desc)
    );

    mcpf_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    mcpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_run_last   (m_axis_tuser),
        .o_packet_end (m_axis_tlast)
    );

endmodule

[tb/sv/tb_mqtt_control_packet_framer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MQTT control packet framer testbench
// Drives start, body and stray transactions into the framer and predicts every
// output byte with its own packet builder, comparing each byte, run end and
// packet end in order. Directed packets cover the length and empty cases, a
// stretch with no idling at all runs back-to-back subscribes and random
// packets, and random packet sequences run under random idling and output
// back-pressure.
// ----------------------------------------------------------------------------
module tb_mqtt_control_packet_framer;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int IDLE_PERCENT  = 31;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] topic_length;
        logic [15:0] payload_length;
        logic [7:0]  body_byte;
        logic        body_last;
    } t_frame_item;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       packet_end;
    } t_frame_byte;

    class t_frame_scoreboard;
        t_frame_byte     expected_bytes[$];
        t_frame_byte     burst[$];
        logic [15:0]     keepalive;
        logic [15:0]     cid_len;
        logic [7:0]      flags;
        logic [15:0]     sub_id;
        mcpf_pkg::t_kind kind;
        bit              open;

        function new();
            keepalive = mcpf_pkg::KEEPALIVE_RESET;
            cid_len   = mcpf_pkg::CID_LEN_RESET;
            flags     = mcpf_pkg::FLAGS_RESET;
            sub_id    = 16'd1;
            kind      = mcpf_pkg::KIND_CONNECT;
            open      = 1'b0;
        endfunction

        function void note_reg(logic [1:0] index, logic [15:0] data);
            case (index)
                mcpf_pkg::CFG_KEEPALIVE: keepalive = data;
                mcpf_pkg::CFG_CID_LEN:   cid_len = data;
                mcpf_pkg::CFG_FLAGS:     flags = data[7:0];
                default: ;
            endcase
        endfunction

        function void put(logic [7:0] value, logic packet_end);
            t_frame_byte b;
            b.value      = value;
            b.run_last   = 1'b0;
            b.packet_end = packet_end;
            burst.push_back(b);
        endfunction

        function void put_rem_len(int unsigned len);
            int unsigned n;
            logic [7:0]  digit;
            n = 0;
            do begin
                digit = 8'(len & 32'h7F);
                len = len >> 7;
                if (len != 0) digit = digit | mcpf_pkg::VARINT_MORE;
                put(digit, 1'b0);
                n++;
            end while (len != 0 && n < 3);
        endfunction

        // Builds the bytes one accepted transaction causes and queues them.
        function int note_input(t_frame_item it);
            string       proto;
            logic        empty;
            t_frame_byte tail;
            proto = "MQTT";
            burst.delete();
            case (it.command)
                mcpf_pkg::CMD_CONNECT: begin
                    empty = (cid_len == 16'd0);
                    kind = mcpf_pkg::KIND_CONNECT;
                    put(mcpf_pkg::HDR_CONNECT, 1'b0);
                    put_rem_len(int'(mcpf_pkg::CONNECT_FIXED_LEN) + int'(cid_len));
                    put(8'h00, 1'b0);
                    put(mcpf_pkg::NAME_LENGTH, 1'b0);
                    for (int i = 0; i < 4; i++) put(proto[i], 1'b0);
                    put(mcpf_pkg::PROTO_LEVEL, 1'b0);
                    put(flags, 1'b0);
                    put(keepalive[15:8], 1'b0);
                    put(keepalive[7:0], 1'b0);
                    put(cid_len[15:8], 1'b0);
                    put(cid_len[7:0], empty);
                    open = !empty;
                end
                mcpf_pkg::CMD_PUBLISH: begin
                    empty = (it.topic_length == 16'd0 && it.payload_length == 16'd0);
                    kind = mcpf_pkg::KIND_PUBLISH;
                    put(mcpf_pkg::HDR_PUBLISH, 1'b0);
                    put_rem_len(int'(mcpf_pkg::PUBLISH_FIXED_LEN) + int'(it.topic_length)
                                + int'(it.payload_length));
                    put(it.topic_length[15:8], 1'b0);
                    put(it.topic_length[7:0], empty);
                    open = !empty;
                end
                mcpf_pkg::CMD_SUBSCRIBE: begin
                    empty = (it.topic_length == 16'd0);
                    kind = mcpf_pkg::KIND_SUBSCRIBE;
                    put(mcpf_pkg::HDR_SUBSCRIBE, 1'b0);
                    put_rem_len(int'(mcpf_pkg::SUBSCRIBE_FIXED_LEN)
                                + int'(it.topic_length));
                    put(sub_id[15:8], 1'b0);
                    put(sub_id[7:0], 1'b0);
                    sub_id = sub_id + 16'd1;
                    put(it.topic_length[15:8], 1'b0);
                    put(it.topic_length[7:0], 1'b0);
                    if (empty) put(mcpf_pkg::QOS_BYTE, 1'b1);
                    open = !empty;
                end
                mcpf_pkg::CMD_PING: begin
                    kind = mcpf_pkg::KIND_PING;
                    put(mcpf_pkg::HDR_PING, 1'b0);
                    put(8'h00, 1'b1);
                    open = 1'b0;
                end
                mcpf_pkg::CMD_BODY: begin
                    if (open) begin
                        if (it.body_last) begin
                            if (kind == mcpf_pkg::KIND_SUBSCRIBE) begin
                                put(it.body_byte, 1'b0);
                                put(mcpf_pkg::QOS_BYTE, 1'b1);
                            end else begin
                                put(it.body_byte, 1'b1);
                            end
                            open = 1'b0;
                        end else begin
                            put(it.body_byte, 1'b0);
                        end
                    end
                end
                default: ;
            endcase
            if (burst.size() > 0) begin
                tail = burst.pop_back();
                tail.run_last = 1'b1;
                burst.push_back(tail);
            end
            foreach (burst[i]) expected_bytes.push_back(burst[i]);
            return burst.size();
        endfunction

        function string check_byte(t_frame_byte got);
            t_frame_byte want;
            if (expected_bytes.size() == 0)
                return $sformatf("byte %02h run_last %0b packet_end %0b with nothing expected",
                                 got.value, got.run_last, got.packet_end);
            want = expected_bytes.pop_front();
            if (got.value != want.value || got.run_last != want.run_last
                    || got.packet_end != want.packet_end)
                return $sformatf("byte %02h run_last %0b packet_end %0b, expected %02h %0b %0b",
                                 got.value, got.run_last, got.packet_end,
                                 want.value, want.run_last, want.packet_end);
            return "";
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    t_frame_scoreboard sb;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    bit                no_idle = 1'b0;
    bit                hold_pending = 1'b0;
    string             check_msg;

    mqtt_control_packet_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_msg = sb.check_byte('{m_axis_tdata, m_axis_tuser, m_axis_tlast});
            if (check_msg != "") report_mismatch(check_msg);
        end
    end

    // Output side: random back-pressure, or a long hold when one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic send_item(input t_frame_item it, output int unsigned produced);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, it.body_byte, it.payload_length, it.topic_length, it.command};
        s_axis_tlast  <= it.body_last;
        do @(posedge i_clk); while (!s_axis_tready);
        produced = sb.note_input(it);
    endtask

    task automatic send(logic [2:0] command, logic [15:0] topic_length,
                        logic [15:0] payload_length, logic [7:0] body_byte, logic body_last);
        t_frame_item it;
        int unsigned produced;
        it = '{command, topic_length, payload_length, body_byte, body_last};
        send_item(it, produced);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_reg(index, data);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_frame_item random_item();
        t_frame_item it;
        it.command        = 3'($urandom);
        it.topic_length   = 16'($urandom);
        it.payload_length = 16'($urandom);
        it.body_byte      = 8'($urandom);
        it.body_last      = 1'($urandom);
        return it;
    endfunction

    // Mostly well-formed packets with random content, some stray transactions.
    task automatic random_packets(int unsigned target);
        t_frame_item it;
        int unsigned produced;
        int unsigned total;
        int unsigned body_count;
        bit          drop_last;
        total = 0;
        while (total < target) begin
            it = random_item();
            if ($urandom_range(99) < 15) begin
                send_item(it, produced);
                total++;
            end else begin
                it.command = 3'($urandom_range(int'(mcpf_pkg::CMD_PING)));
                if ($urandom_range(99) < 80) begin
                    it.topic_length   = 16'($urandom_range(20));
                    it.payload_length = 16'($urandom_range(20));
                end
                send_item(it, produced);
                total++;
                body_count = $urandom_range(6);
                drop_last  = ($urandom_range(99) < 10);
                for (int unsigned i = 0; i < body_count; i++) begin
                    it = random_item();
                    it.command   = mcpf_pkg::CMD_BODY;
                    it.body_last = (i == body_count - 1) && !drop_last;
                    send_item(it, produced);
                    total++;
                end
            end
        end
    endtask

    task automatic random_config();
        write_reg(mcpf_pkg::CFG_KEEPALIVE, 16'($urandom));
        write_reg(mcpf_pkg::CFG_CID_LEN,
                  ($urandom_range(99) < 80) ? 16'($urandom_range(20)) : 16'($urandom));
        write_reg(mcpf_pkg::CFG_FLAGS, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [2:0] cmd;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stray transactions: body with no open packet and undefined commands.
        send(mcpf_pkg::CMD_BODY, 16'h1234, 16'h5678, 8'h3C, 1'b1);
        cmd = mcpf_pkg::CMD_BODY;
        repeat (3) begin
            cmd = cmd + 3'd1;
            send(cmd, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        end
        send(mcpf_pkg::CMD_PING, 16'h0, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_CONNECT, 16'h0, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_BODY, 16'h0, 16'h0, 8'h00, 1'b0);
        send(mcpf_pkg::CMD_BODY, 16'h0, 16'h0, 8'hFF, 1'b1);
        send(mcpf_pkg::CMD_PUBLISH, 16'h0, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_PUBLISH, 16'hFFFF, 16'hFFFF, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_BODY, 16'h0, 16'h0, 8'hA5, 1'b0);
        send(mcpf_pkg::CMD_BODY, 16'h0, 16'h0, 8'h5A, 1'b1);
        send(mcpf_pkg::CMD_SUBSCRIBE, 16'h0, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_SUBSCRIBE, 16'hFFFF, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_BODY, 16'h0, 16'h0, 8'h12, 1'b1);
        // Remaining length at the one, two and three byte boundaries; each start
        // abandons the packet left open by the one before.
        send(mcpf_pkg::CMD_PUBLISH, 16'd125, 16'd0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_PUBLISH, 16'd126, 16'd0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_SUBSCRIBE, 16'd16378, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_SUBSCRIBE, 16'd16379, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_BODY, 16'h0, 16'h0, 8'h81, 1'b1);
        send(mcpf_pkg::CMD_PING, 16'h0, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_BODY, 16'h0, 16'h0, 8'h77, 1'b1);

        settle();
        write_reg(mcpf_pkg::CFG_FLAGS, 16'hFFFF);
        write_reg(mcpf_pkg::CFG_KEEPALIVE, 16'hFFFF);
        write_reg(mcpf_pkg::CFG_CID_LEN, 16'h0000);
        i_cfg_valid <= 1'b0;
        send(mcpf_pkg::CMD_CONNECT, 16'h0, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_BODY, 16'h0, 16'h0, 8'h44, 1'b1);

        settle();
        write_reg(mcpf_pkg::CFG_KEEPALIVE, 16'h0000);
        write_reg(mcpf_pkg::CFG_CID_LEN, 16'hFFFF);
        write_reg(mcpf_pkg::CFG_FLAGS, 16'h0000);
        write_reg(2'(mcpf_pkg::CFG_FLAGS + 2'd1), 16'($urandom));
        i_cfg_valid <= 1'b0;
        send(mcpf_pkg::CMD_CONNECT, 16'h0, 16'h0, 8'h0, 1'b0);
        send(mcpf_pkg::CMD_BODY, 16'h0, 16'h0, 8'h99, 1'b1);

        // Back-to-back empty subscribes and random packets with no idling.
        settle();
        no_idle = 1'b1;
        repeat (8) begin
            send(mcpf_pkg::CMD_SUBSCRIBE, 16'h0, 16'($urandom), 8'($urandom), 1'($urandom));
        end
        random_packets(20);
        settle();
        no_idle = 1'b0;

        random_config();
        random_packets(20);
        settle();
        random_packets(20);

        settle();
        random_config();
        hold_pending = 1'b1;
        random_packets(40);

        settle();
        write_reg(mcpf_pkg::CFG_CID_LEN, 16'h0000);
        i_cfg_valid <= 1'b0;
        random_packets(15);

        settle();
        random_config();
        random_packets(15);

        s_axis_tvalid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
